// ===== hdl/tiered_cache_eviction_index_macros.svh =====
// Assertion macros for the tiered cache eviction index checker.
// Included by the checker file; no other dependencies.
`ifndef TIERED_CACHE_EVICTION_INDEX_MACROS_SVH
`define TIERED_CACHE_EVICTION_INDEX_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCEI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define TCEI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/tcei_pkg.sv =====
// Types, register codes and counter helper for the tiered cache eviction index.
// No dependencies.
package tcei_pkg;

   localparam logic [0:0] REG_DEVICE_CAP = 1'b0;
   localparam logic [0:0] REG_HOST_CAP   = 1'b1;

   typedef struct packed {
      logic        host_ok;
      logic        dev_ok;
      logic [7:0]  refs;
      logic        stor;
      logic        host;
      logic        dev;
      logic [15:0] pages;
      logic        valid;
   } rec_info_type;

   typedef struct packed {
      logic [15:0]  priority_key;
      logic [31:0]  order_key;
      rec_info_type info;
   } rec_type;

   typedef struct packed {
      logic [9:0]  node_id;
      logic        active;
      logic [15:0] pages_held;
      logic [15:0] priority_req;
      logic [31:0] access_order;
      logic        on_device;
      logic        on_host;
      logic        in_storage;
      logic [7:0]  host_refs;
      logic        device_leaf_ok;
      logic        host_leaf_ok;
      logic [31:0] reserved_pages;
   } req_type;

   typedef struct packed {
      logic [31:0] device_excess;
      logic [31:0] host_excess;
      logic [31:0] storage_pages;
      logic        device_victim_found;
      logic [9:0]  device_victim;
      logic        host_victim_found;
      logic [9:0]  host_victim;
      logic        count_error;
   } rsp_type;

   typedef enum logic [1:0] {CTR_HOLD, CTR_SUB, CTR_ADD} ctr_kind_type;

   typedef struct packed {
      ctr_kind_type kind;
      rec_info_type info;
   } ctr_op_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_OLD, ST_NEW, ST_SCAN, ST_DRAIN, ST_SUM,
      ST_EXCESS, ST_DONE
   } state_type;

   // returns {error, next value}; on error the value is unchanged
   function automatic logic [32:0] bump(input logic [31:0] cnt, input logic [15:0] amt,
                                        input logic up);
      logic [32:0] sum;
      begin
         sum = {1'b0, cnt} + {17'd0, amt};
         if (up) begin
            bump = sum[32] ? {1'b1, cnt} : {1'b0, sum[31:0]};
         end else begin
            bump = (cnt < {16'd0, amt}) ? {1'b1, cnt} : {1'b0, cnt - {16'd0, amt}};
         end
      end
   endfunction

endpackage

// ===== hdl/tcei_req_if.sv =====
// Request channel interface: valid/ready handshake with a req_type payload.
// Depends on tcei_pkg.
interface tcei_req_if;
   import tcei_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tcei_rsp_if.sv =====
// Response channel interface: valid/ready handshake with a rsp_type payload.
// Depends on tcei_pkg.
interface tcei_rsp_if;
   import tcei_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tcei_table.sv =====
// Node record memory: one write port, one read port, registered read data.
// Depends on tcei_pkg.
module tcei_table #(
   parameter int NODE_SLOTS = 1024,
   parameter int IDX_W = $clog2(NODE_SLOTS)
) (
   input  logic                 clock,
   input  logic [IDX_W-1:0]     rd_addr,
   output tcei_pkg::rec_type    rd_data,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  tcei_pkg::rec_type    wr_data
);
   import tcei_pkg::*;

   rec_type mem [NODE_SLOTS];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/tcei_counters.sv =====
// Device, host and storage occupancy counters with overflow/underflow check.
// Depends on tcei_pkg.
module tcei_counters (
   input  logic                 clock,
   input  logic                 reset,
   input  tcei_pkg::ctr_op_type op,
   output logic [31:0]          device_count,
   output logic [31:0]          host_count,
   output logic [31:0]          storage_count,
   output logic                 err
);
   import tcei_pkg::*;

   logic [31:0] dev_ff, host_ff, stor_ff;
   logic [31:0] dev_in, host_in, stor_in;
   logic [32:0] dev_b, host_b, stor_b;
   logic        up, apply;

   always_comb begin
      up    = (op.kind == CTR_ADD);
      apply = (op.kind != CTR_HOLD) && op.info.valid;
      dev_b  = bump(dev_ff, op.info.pages, up);
      host_b = bump(host_ff, op.info.pages, up);
      stor_b = bump(stor_ff, op.info.pages, up);
      dev_in  = dev_ff;
      host_in = host_ff;
      stor_in = stor_ff;
      err     = 1'b0;
      if (apply && op.info.dev) begin
         dev_in = dev_b[31:0];
         err    = err | dev_b[32];
      end
      if (apply && op.info.host) begin
         host_in = host_b[31:0];
         err     = err | host_b[32];
      end
      if (apply && op.info.stor) begin
         stor_in = stor_b[31:0];
         err     = err | stor_b[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff  <= '0;
         host_ff <= '0;
         stor_ff <= '0;
      end else begin
         dev_ff  <= dev_in;
         host_ff <= host_in;
         stor_ff <= stor_in;
      end
   end

   assign device_count  = dev_ff;
   assign host_count    = host_ff;
   assign storage_count = stor_ff;
endmodule

// ===== hdl/tcei_select.sv =====
// Running minimum of (priority, access order, slot) for device and host victims.
// Slots arrive in ascending order, so a strict compare keeps the lower id on ties.
// Depends on tcei_pkg.
module tcei_select #(
   parameter int IDX_W = 10
) (
   input  logic                 clock,
   input  logic                 start,
   input  logic                 cmp_valid,
   input  logic [IDX_W-1:0]     cmp_idx,
   input  tcei_pkg::rec_type    rec,
   output logic                 dev_found,
   output logic [IDX_W-1:0]     dev_victim,
   output logic                 host_found,
   output logic [IDX_W-1:0]     host_victim
);
   import tcei_pkg::*;

   logic             dfound_ff, hfound_ff, dfound_in, hfound_in;
   logic [47:0]      dkey_ff, hkey_ff, dkey_in, hkey_in, key;
   logic [IDX_W-1:0] dvic_ff, hvic_ff, dvic_in, hvic_in;

   always_comb begin
      key       = {rec.priority_key, rec.order_key};
      dfound_in = dfound_ff;
      hfound_in = hfound_ff;
      dkey_in   = dkey_ff;
      hkey_in   = hkey_ff;
      dvic_in   = dvic_ff;
      hvic_in   = hvic_ff;
      if (start) begin
         dfound_in = 1'b0;
         hfound_in = 1'b0;
         dvic_in   = '0;
         hvic_in   = '0;
      end else if (cmp_valid && rec.info.valid) begin
         if (rec.info.dev_ok && (!dfound_ff || key < dkey_ff)) begin
            dfound_in = 1'b1;
            dkey_in   = key;
            dvic_in   = cmp_idx;
         end
         if (rec.info.host_ok && rec.info.refs == 8'd0 && (!hfound_ff || key < hkey_ff)) begin
            hfound_in = 1'b1;
            hkey_in   = key;
            hvic_in   = cmp_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      dfound_ff <= dfound_in;
      hfound_ff <= hfound_in;
      dkey_ff   <= dkey_in;
      hkey_ff   <= hkey_in;
      dvic_ff   <= dvic_in;
      hvic_ff   <= hvic_in;
   end

   assign dev_found   = dfound_ff;
   assign dev_victim  = dvic_ff;
   assign host_found  = hfound_ff;
   assign host_victim = hvic_ff;
endmodule

// ===== hdl/tiered_cache_eviction_index.sv =====
// Channel   Dir  Handshake         Beat contents
// req_bus   in   valid/ready       node record update and host reservation
// rsp_bus   out  valid/ready       excess, storage total, victims, error flag
// csr_*     in   write enable      capacity registers, index 0 device, 1 host
// For an active in-range update the old record's counts are taken out and the new ones added;
// a removal only takes out the old counts and clears the slot, and the root or an id out of
// range changes no record; the victim scan then reads the record memory one slot per cycle.
// The next beat is taken in the idle state after the result loads.
// Reset clears the record memory slot by slot; no beat is taken then.
// A finished result waits in the response register; the next request is taken meanwhile,
// and its result stalls in the last step until the register frees.
// Depends on tcei_pkg, tcei_req_if, tcei_rsp_if, tcei_table, tcei_counters, tcei_select.
module tiered_cache_eviction_index #(
   parameter int NODE_SLOTS = 1024
) (
   input  logic       clock,
   input  logic       reset,
   tcei_req_if.sink   req_bus,
   tcei_rsp_if.source rsp_bus,
   input  logic       csr_we,
   input  logic [0:0] csr_index,
   input  logic [31:0] csr_wdata
);
   import tcei_pkg::*;

   localparam int IDX_W = $clog2(NODE_SLOTS);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NODE_SLOTS - 1);

   state_type        state_ff, state_in;
   req_type          req_ff;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic [31:0]      dev_cap_ff, host_cap_ff;
   logic             err_ff, err_in;
   logic [32:0]      hsum_ff;
   logic [31:0]      dev_exc_ff, host_exc_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   logic             accept, load, in_range;
   logic [IDX_W-1:0] rd_addr, wr_addr, node_idx;
   logic             wr_en;
   rec_type          rd_data, wr_data, new_rec;
   ctr_op_type       ctr_op;
   logic [31:0]      dev_cnt, host_cnt, stor_cnt;
   logic             ctr_err;
   logic             dfound, hfound;
   logic [IDX_W-1:0] dvic, hvic;
   logic [32:0]      hdiff;

   tcei_table #(.NODE_SLOTS(NODE_SLOTS), .IDX_W(IDX_W)) u_table (
      .clock, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
   );

   tcei_counters u_counters (
      .clock, .reset, .op(ctr_op), .device_count(dev_cnt), .host_count(host_cnt),
      .storage_count(stor_cnt), .err(ctr_err)
   );

   tcei_select #(.IDX_W(IDX_W)) u_select (
      .clock, .start(accept), .cmp_valid(cmp_vld_ff), .cmp_idx(cmp_idx_ff), .rec(rd_data),
      .dev_found(dfound), .dev_victim(dvic), .host_found(hfound), .host_victim(hvic)
   );

   assign accept   = req_bus.valid && req_bus.ready;
   assign in_range = (req_ff.node_id != 10'd0) && ({22'd0, req_ff.node_id} < 32'(NODE_SLOTS));
   assign node_idx = IDX_W'(req_ff.node_id);
   assign load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      new_rec.priority_key = req_ff.priority_req;
      new_rec.order_key    = req_ff.access_order;
      new_rec.info.valid   = 1'b1;
      new_rec.info.pages   = req_ff.pages_held;
      new_rec.info.dev     = req_ff.on_device;
      new_rec.info.host    = req_ff.on_host;
      new_rec.info.stor    = req_ff.in_storage;
      new_rec.info.refs    = req_ff.host_refs;
      new_rec.info.dev_ok  = req_ff.device_leaf_ok;
      new_rec.info.host_ok = req_ff.host_leaf_ok;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (scan_ff == LAST_SLOT) state_in = ST_IDLE;
         ST_IDLE:   if (req_bus.valid) state_in = ST_READ;
         ST_READ:   state_in = in_range ? ST_OLD : ST_SCAN;
         ST_OLD:    state_in = req_ff.active ? ST_NEW : ST_SCAN;
         ST_NEW:    state_in = ST_SCAN;
         ST_SCAN:   if (scan_ff == LAST_SLOT) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_SUM;
         ST_SUM:    state_in = ST_EXCESS;
         ST_EXCESS: state_in = ST_DONE;
         ST_DONE:   if (load) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_bus.ready = 1'b0;
      rd_addr       = scan_ff;
      wr_en         = 1'b0;
      wr_addr       = node_idx;
      wr_data       = new_rec;
      ctr_op.kind   = CTR_HOLD;
      ctr_op.info   = new_rec.info;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff;
            wr_data = '0;
         end
         ST_IDLE: req_bus.ready = 1'b1;
         ST_READ: rd_addr = node_idx;
         ST_OLD: begin
            // take out the old contribution, store the new record or drop the slot
            ctr_op.kind = CTR_SUB;
            ctr_op.info = rd_data.info;
            wr_en       = 1'b1;
            wr_data     = req_ff.active ? new_rec : '0;
         end
         ST_NEW: ctr_op.kind = CTR_ADD;
         default: ;
      endcase
   end

   always_comb begin
      scan_in = scan_ff;
      if (accept) begin
         scan_in = IDX_W'(1);
      end else if (state_ff == ST_CLEAR || state_ff == ST_SCAN) begin
         scan_in = scan_ff + IDX_W'(1);
      end
      err_in = err_ff | ctr_err;
      if (accept) begin
         err_in = 1'b0;
      end else if (state_ff == ST_EXCESS && host_cap_ff != 32'd0 &&
                   hsum_ff > {1'b0, host_cap_ff} && hdiff[32]) begin
         err_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign hdiff = hsum_ff - {1'b0, host_cap_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dev_cap_ff   <= '0;
         host_cap_ff  <= '0;
         req_ff.reserved_pages <= '0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         cmp_vld_ff   <= (state_ff == ST_SCAN);
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_DEVICE_CAP: dev_cap_ff  <= csr_wdata;
               REG_HOST_CAP:   host_cap_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            req_ff <= req_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_ff;
      hsum_ff    <= {1'b0, host_cnt} + {1'b0, req_ff.reserved_pages};
      if (state_ff == ST_EXCESS) begin
         if (dev_cap_ff == 32'd0 || dev_cnt <= dev_cap_ff) begin
            dev_exc_ff <= '0;
         end else begin
            dev_exc_ff <= dev_cnt - dev_cap_ff;
         end
         if (host_cap_ff == 32'd0 || hsum_ff <= {1'b0, host_cap_ff}) begin
            host_exc_ff <= '0;
         end else if (hdiff[32]) begin
            host_exc_ff <= '1;
         end else begin
            host_exc_ff <= hdiff[31:0];
         end
      end
      if (load) begin
         rsp_data_ff.device_excess       <= dev_exc_ff;
         rsp_data_ff.host_excess         <= host_exc_ff;
         rsp_data_ff.storage_pages       <= stor_cnt;
         rsp_data_ff.device_victim_found <= dfound;
         rsp_data_ff.device_victim       <= 10'(dvic);
         rsp_data_ff.host_victim_found   <= hfound;
         rsp_data_ff.host_victim         <= 10'(hvic);
         rsp_data_ff.count_error         <= err_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;
endmodule

// ===== hdl/tcei_checker.sv =====
// Port-level checker for the tiered cache eviction index, bound to the top level.
// Depends on tiered_cache_eviction_index_macros.svh.
`include "tiered_cache_eviction_index_macros.svh"

module tcei_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       dev_found,
   input logic [9:0] dev_victim,
   input logic       host_found,
   input logic [9:0] host_victim
);
   `TCEI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TCEI_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `TCEI_ASSERT_NOW(a_dev_none_zero, clock, reset, rsp_valid && !dev_found, dev_victim == 10'd0)
   `TCEI_ASSERT_NOW(a_host_none_zero, clock, reset, rsp_valid && !host_found,
      host_victim == 10'd0)
endmodule

bind tiered_cache_eviction_index tcei_checker u_tcei_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_bus.valid),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .dev_found(rsp_bus.data.device_victim_found),
   .dev_victim(rsp_bus.data.device_victim),
   .host_found(rsp_bus.data.host_victim_found),
   .host_victim(rsp_bus.data.host_victim)
);
